// ----- rtl/ftsr_pkg.sv -----
// Shared types and constants for the flat triangle scanline rasterizer.
// No dependencies.
package ftsr_pkg;

    localparam logic [2:0] KIND_SPAN     = 3'd0;
    localparam logic [2:0] KIND_LOADED   = 3'd1;
    localparam logic [2:0] KIND_NOT_FLAT = 3'd2;
    localparam logic [2:0] KIND_ZERO_H   = 3'd3;
    localparam logic [2:0] KIND_IDLE     = 3'd4;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // capture a triangle from the request
        logic div_start;  // launch both edge divisions
        logic span_done;  // emit span, advance row
    } ftsr_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic active;
        logic div_busy;
    } ftsr_stat_t;

endpackage

// ----- rtl/flat_triangle_scanline_rasterizer_unit.sv -----
// Flat-top / flat-bottom scanline triangle rasterizer. A load request
// (operation 0) sorts three Q11.4 vertices and answers at once with loaded,
// not-flat or zero-height. Each step request (operation 1) returns one clipped,
// rounded scanline span while a triangle is active, else an idle result. The
// span comes from the two bit-serial edge dividers running side by side over
// the edge numerator (18 + row offset width + EDGE_FRAC_BITS - COORD_FRAC_BITS
// bits); load and idle requests bypass the dividers.
// One request is in flight at a time; the result sits in an output register.
// Depends on ftsr_pkg, ftsr_ctrl, ftsr_datapath, ftsr_divider.
module flat_triangle_scanline_rasterizer_unit
    import ftsr_pkg::*;
#(
    parameter int MAX_SCREEN      = 1024,
    parameter int COORD_FRAC_BITS = 4,
    parameter int EDGE_FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [15:0] vertex0_x,
    input  logic signed [15:0] vertex0_y,
    input  logic signed [15:0] vertex1_x,
    input  logic signed [15:0] vertex1_y,
    input  logic signed [15:0] vertex2_x,
    input  logic signed [15:0] vertex2_y,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         kind,
    output logic [9:0]         span_row,
    output logic [9:0]         span_start,
    output logic [9:0]         span_end,
    output logic               span_empty,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic               last_span
);
    ftsr_cmd_t  cmd;
    ftsr_stat_t stat;
    logic       capture;
    logic [2:0] kind_sel, load_kind;
    logic [9:0] d_row, d_start, d_end;
    logic       d_empty, d_last;
    logic [7:0] d_r, d_g, d_b;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    ftsr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .out_valid(out_valid), .out_ready(out_ready),
        .cmd(cmd), .stat(stat), .capture(capture), .kind_sel(kind_sel)
    );

    ftsr_datapath #(
        .MAX_SCREEN(MAX_SCREEN), .COORD_FRAC_BITS(COORD_FRAC_BITS),
        .EDGE_FRAC_BITS(EDGE_FRAC_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index[0]), .cfg_data(cfg_data),
        .vertex0_x(vertex0_x), .vertex0_y(vertex0_y),
        .vertex1_x(vertex1_x), .vertex1_y(vertex1_y),
        .vertex2_x(vertex2_x), .vertex2_y(vertex2_y),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
        .load_kind(load_kind), .span_row(d_row), .span_start(d_start),
        .span_end(d_end), .span_empty(d_empty), .red_out(d_r),
        .green_out(d_g), .blue_out(d_b), .last_span(d_last)
    );

    // Output register: non-span results carry zeros beside kind.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            if (kind_sel == KIND_SPAN)
            begin
                kind <= KIND_SPAN; span_row <= d_row; span_start <= d_start;
                span_end <= d_end; span_empty <= d_empty; red_out <= d_r;
                green_out <= d_g; blue_out <= d_b; last_span <= d_last;
            end
            else
            begin
                kind <= (kind_sel == KIND_LOADED) ? load_kind : KIND_IDLE;
                span_row <= '0; span_start <= '0; span_end <= '0;
                span_empty <= 1'b0; red_out <= '0; green_out <= '0;
                blue_out <= '0; last_span <= 1'b0;
            end
        end
    end
endmodule

// ----- rtl/ftsr_divider.sv -----
// Restoring divider: signed floor division, one quotient bit per cycle.
// Depends on nothing.
module ftsr_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 18
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    busy,
    output logic signed [NUM_W-1:0] quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic             neg_reg, rem_nz;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [DEN_W+1:0] trial;
    logic [NUM_W-1:0] q_res;

    always_comb
    begin
        trial  = {r_reg, q_reg[NUM_W-1]} - {2'b00, d_reg};
        q_next = {q_reg[NUM_W-2:0], 1'b0};
        r_next = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        if (!trial[DEN_W+1])
        begin
            q_next[0] = 1'b1;
            r_next    = trial[DEN_W:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[NUM_W-1] ? NUM_W'(-num) : num;
            d_reg   <= den[DEN_W-1] ? DEN_W'(-den) : den;
            r_reg   <= '0;
            neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign rem_nz = (r_reg != '0);
    // floor: negate magnitude, minus one when a remainder is left
    assign q_res  = neg_reg ? (~q_reg + NUM_W'(!rem_nz)) : q_reg;
    assign quot   = $signed(q_res);
    assign busy   = busy_reg;
endmodule

// ----- rtl/ftsr_datapath.sv -----
// Datapath: triangle setup, row state, left and right edge dividers, span rounding.
// Depends on ftsr_pkg and ftsr_divider.
module ftsr_datapath
    import ftsr_pkg::*;
#(
    parameter int MAX_SCREEN      = 1024,
    parameter int COORD_FRAC_BITS = 4,
    parameter int EDGE_FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ftsr_cmd_t          cmd,
    output ftsr_stat_t         stat,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic signed [15:0] vertex0_x,
    input  logic signed [15:0] vertex0_y,
    input  logic signed [15:0] vertex1_x,
    input  logic signed [15:0] vertex1_y,
    input  logic signed [15:0] vertex2_x,
    input  logic signed [15:0] vertex2_y,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,
    output logic [2:0]         load_kind,
    output logic [9:0]         span_row,
    output logic [9:0]         span_start,
    output logic [9:0]         span_end,
    output logic               span_empty,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic               last_span
);
    localparam int UPS   = EDGE_FRAC_BITS - COORD_FRAC_BITS;
    // row width holds any integer row of a vertex and the clip limit
    localparam int RW    = ((16 - COORD_FRAC_BITS > $clog2(MAX_SCREEN + 1)) ?
                            16 - COORD_FRAC_BITS : $clog2(MAX_SCREEN + 1)) + 1;
    localparam int TW    = RW + COORD_FRAC_BITS + 2;
    localparam int NUM_W = 17 + TW + UPS + 1;
    localparam int EW    = NUM_W + 2;
    localparam int SW    = $clog2(MAX_SCREEN + 1) + 1;

    logic [10:0] width_reg, height_reg;
    logic signed [15:0] apex_x_reg, apex_y_reg, bl_x_reg, br_x_reg, base_y_reg;
    logic signed [RW-1:0] cur_row_reg, fin_row_reg;
    logic going_down_reg, active_reg;
    logic [23:0] color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1000;
            height_reg <= 11'd1000;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SCREEN_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    logic signed [SW-1:0] w_eff, h_eff;
    always_comb
    begin
        w_eff = (width_reg == 0) ? SW'(1) :
                ({1'b0, width_reg} > 12'(MAX_SCREEN)) ? SW'(MAX_SCREEN) : SW'(width_reg);
        h_eff = (height_reg == 0) ? SW'(1) :
                ({1'b0, height_reg} > 12'(MAX_SCREEN)) ? SW'(MAX_SCREEN) : SW'(height_reg);
    end

    // Load: stable three-element sort by y
    logic signed [15:0] sx [3];
    logic signed [15:0] sy [3];
    logic signed [15:0] tx, ty;
    logic signed [RW-1:0] first, last, fl_apex, ce_apex, fl_base, ce_base;
    logic signed [RW-1:0] hm1;
    logic flat_top, flat_bot, vis;
    logic signed [15:0] nbx, nby, nbxa, nbxb;

    always_comb
    begin
        tx = '0;
        ty = '0;
        sx[0] = vertex0_x; sy[0] = vertex0_y;
        sx[1] = vertex1_x; sy[1] = vertex1_y;
        sx[2] = vertex2_x; sy[2] = vertex2_y;
        if (sy[0] > sy[1]) begin tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx; sy[1] = ty; end
        if (sy[1] > sy[2]) begin tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2];
            sx[2] = tx; sy[2] = ty; end
        if (sy[0] > sy[1]) begin tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx; sy[1] = ty; end
        flat_top = (sy[0] == sy[1]);
        flat_bot = (sy[1] == sy[2]);
        hm1 = RW'(h_eff) - RW'(1);
        if (flat_top)
        begin
            nbx = sx[2]; nby = sy[2]; tx = sy[0]; nbxa = sx[0]; nbxb = sx[1];
        end
        else
        begin
            nbx = sx[0]; nby = sy[0]; tx = sy[1]; nbxa = sx[1]; nbxb = sx[2];
        end
        fl_apex = RW'(nby >>> COORD_FRAC_BITS);
        ce_apex = RW'((17'(nby) + 17'((1 << COORD_FRAC_BITS) - 1)) >>> COORD_FRAC_BITS);
        fl_base = RW'(tx >>> COORD_FRAC_BITS);
        ce_base = RW'((17'(tx) + 17'((1 << COORD_FRAC_BITS) - 1)) >>> COORD_FRAC_BITS);
        if (flat_top)
        begin
            first = (fl_apex > hm1) ? hm1 : fl_apex;
            last  = (ce_base < 0) ? '0 : ce_base;
            vis   = first >= last;
        end
        else
        begin
            first = (ce_apex < 0) ? '0 : ce_apex;
            last  = (fl_base > hm1) ? hm1 : fl_base;
            vis   = first <= last;
        end
        if (flat_top && flat_bot)
            load_kind = KIND_ZERO_H;
        else if (flat_top || flat_bot)
            load_kind = KIND_LOADED;
        else
            load_kind = KIND_NOT_FLAT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            going_down_reg <= 1'b0;
            cur_row_reg    <= '0;
            fin_row_reg    <= '0;
            apex_x_reg     <= '0;
            apex_y_reg     <= '0;
            bl_x_reg       <= '0;
            br_x_reg       <= '0;
            base_y_reg     <= '0;
            color_reg      <= '0;
        end
        else if (cmd.load)
        begin
            color_reg  <= {red_in, green_in, blue_in};
            active_reg <= 1'b0;
            if (load_kind == KIND_LOADED)
            begin
                apex_x_reg     <= nbx;
                apex_y_reg     <= nby;
                base_y_reg     <= tx;
                bl_x_reg       <= (nbxa < nbxb) ? nbxa : nbxb;
                br_x_reg       <= (nbxa < nbxb) ? nbxb : nbxa;
                going_down_reg <= flat_top;
                cur_row_reg    <= first;
                fin_row_reg    <= last;
                active_reg     <= vis;
            end
        end
        else if (cmd.span_done)
        begin
            if (cur_row_reg == fin_row_reg)
                active_reg <= 1'b0;
            else if (going_down_reg)
                cur_row_reg <= cur_row_reg - 1'b1;
            else
                cur_row_reg <= cur_row_reg + 1'b1;
        end
    end

    // Numerators: dx * tn * 2^UPS, combinational, captured by the dividers on start
    logic signed [17:0] dy;
    logic signed [16:0] dxl, dxr;
    logic signed [TW-1:0] tn;
    logic signed [NUM_W-1:0] num_l, num_r;
    logic signed [NUM_W-1:0] ql, qr;
    logic busy_l, busy_r;

    always_comb
    begin
        dy  = 18'(base_y_reg) - 18'(apex_y_reg);
        dxl = 17'(bl_x_reg) - 17'(apex_x_reg);
        dxr = 17'(br_x_reg) - 17'(apex_x_reg);
        tn  = (TW'(cur_row_reg) <<< COORD_FRAC_BITS) - TW'(apex_y_reg);
        num_l = NUM_W'(dxl * tn) <<< UPS;
        num_r = NUM_W'(dxr * tn) <<< UPS;
    end

    ftsr_divider #(.NUM_W(NUM_W), .DEN_W(18)) u_div_l (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .num(num_l), .den(dy), .busy(busy_l), .quot(ql)
    );
    ftsr_divider #(.NUM_W(NUM_W), .DEN_W(18)) u_div_r (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .num(num_r), .den(dy), .busy(busy_r), .quot(qr)
    );

    logic signed [EW-1:0] ex_l, ex_r, hi, cl, cr;
    logic [EW-1:0] s_full, e_full;
    always_comb
    begin
        ex_l = (EW'(apex_x_reg) <<< UPS) + EW'(ql);
        ex_r = (EW'(apex_x_reg) <<< UPS) + EW'(qr);
        hi   = EW'(w_eff - SW'(1)) <<< EDGE_FRAC_BITS;
        cl   = (ex_l < 0) ? '0 : (ex_l > hi) ? hi : ex_l;
        cr   = (ex_r < 0) ? '0 : (ex_r > hi) ? hi : ex_r;
        s_full = (cl + EW'((1 << EDGE_FRAC_BITS) - 2)) >> EDGE_FRAC_BITS;
        e_full = (cr + EW'(1)) >> EDGE_FRAC_BITS;
    end

    assign span_row   = cur_row_reg[9:0];
    assign span_start = s_full[9:0];
    assign span_end   = e_full[9:0];
    assign span_empty = s_full > e_full;
    assign red_out    = color_reg[23:16];
    assign green_out  = color_reg[15:8];
    assign blue_out   = color_reg[7:0];
    assign last_span  = cur_row_reg == fin_row_reg;
    assign stat.active   = active_reg;
    assign stat.div_busy = busy_l | busy_r;
endmodule

// ----- rtl/ftsr_ctrl.sv -----
// Controller: request sequencing and output register handshake.
// Depends on ftsr_pkg.
module ftsr_ctrl
    import ftsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       operation,
    output logic       out_valid,
    input  logic       out_ready,
    output ftsr_cmd_t  cmd,
    input  ftsr_stat_t stat,
    output logic       capture,
    output logic [2:0] kind_sel
);
    typedef enum logic [1:0] { ST_IDLE, ST_LAUNCH, ST_DIVIDE, ST_EMIT } state_t;

    state_t state_reg;
    logic   ov_reg;
    logic   free;

    // output register can take a new result
    assign free     = !ov_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && free;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd.load      = in_valid && in_ready && !operation;
        cmd.div_start = state_reg == ST_LAUNCH;
        cmd.span_done = (state_reg == ST_EMIT) && free;
        capture = (in_valid && in_ready && (!operation || !stat.active)) || cmd.span_done;
        kind_sel = cmd.span_done ? KIND_SPAN : (!operation ? KIND_LOADED : KIND_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (capture)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (in_valid && in_ready && operation && stat.active)
                        state_reg <= ST_LAUNCH;
                ST_LAUNCH: state_reg <= ST_DIVIDE;
                ST_DIVIDE:
                    if (!stat.div_busy)
                        state_reg <= ST_EMIT;
                ST_EMIT:
                    if (free)
                        state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
